FILE: design/bat_pkg.sv
`default_nettype none

package bat_pkg;

    localparam int MAX_REQUESTERS = 16;
    localparam int TICKET_WIDTH   = 16;

    localparam int IDX_W    = $clog2(MAX_REQUESTERS);
    localparam int CNT_W    = $clog2(MAX_REQUESTERS + 1);
    localparam int REQ_W    = 4;
    localparam int CFG_W    = 5;
    localparam int GIVEN_W  = 16;
    localparam int HOLDER_W = 4;

    localparam int CMP_A = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int CMP_W = ((CMP_A > REQ_W) ? CMP_A : REQ_W) + 1;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

    typedef logic [TICKET_WIDTH-1:0] t_ticket;

    localparam t_ticket TICKET_MAX = '1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_STATE    = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        REQ_ENTER   = 1'b0,
        REQ_RELEASE = 1'b1
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAX_SCAN,
        S_DECIDE,
        S_MIN_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_ticket          data;
    } t_wr_req;

endpackage

`default_nettype wire

FILE: design/bat_ticket_store.sv
`default_nettype none

module bat_ticket_store (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  bat_pkg::t_wr_req            i_wr,
    input  wire  [bat_pkg::IDX_W-1:0]   i_rd_addr,
    output bat_pkg::t_ticket            o_rd_data
);
    import bat_pkg::*;

    t_ticket                   r_mem [MAX_REQUESTERS];
    logic [MAX_REQUESTERS-1:0] r_valid;
    t_ticket                   r_rd_data;
    logic                      r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

FILE: design/bakery_ticket_arbiter_unit.sv
// after start is taken the block walks the ticket ram for the largest ticket and the caller's
// own, decides and writes, then walks it again for the lowest live ticket (an out-of-range
// index skips the first walk); busy drops in the cycle after the strobe, one item at a time
// results cannot be stalled: each is shown for one cycle under o_strobe
// reset (synchronous, active low) empties every ticket at once and sets the count to 16
`default_nettype none

module bakery_ticket_arbiter_unit (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire                           i_req_type,
    input  wire  [bat_pkg::REQ_W-1:0]     i_requester,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [bat_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_strobe,
    output bat_pkg::t_status              o_status,
    output logic [bat_pkg::GIVEN_W-1:0]   o_ticket_given,
    output logic                          o_holder_valid,
    output logic [bat_pkg::HOLDER_W-1:0]  o_holder_index
);
    import bat_pkg::*;

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_active;
    logic [CNT_W-1:0] r_n, n_n;
    t_req             r_req, n_req;
    logic [IDX_W-1:0] r_who, n_who;
    logic [CNT_W-1:0] r_k, n_k;
    logic             r_dv, n_dv;
    logic [IDX_W-1:0] r_dk, n_dk;
    t_ticket          r_max, n_max;
    t_ticket          r_own, n_own;
    t_ticket          r_best, n_best;
    logic [IDX_W-1:0] r_best_idx, n_best_idx;
    logic             r_found, n_found;
    t_status          r_status, n_status;
    t_ticket          r_given, n_given;

    logic             accept;
    logic             in_range;
    logic [CNT_W-1:0] clamp_n;
    logic             issue;
    logic             scan_end;
    t_ticket          rd_data;
    t_wr_req          wr;

    assign accept   = start && !busy;
    assign clamp_n  = (CMP_W'(r_active) > CMP_W'(MAX_REQUESTERS)) ? CNT_W'(MAX_REQUESTERS)
                                                                  : CNT_W'(r_active);
    assign in_range = CMP_W'(i_requester) < CMP_W'(clamp_n);
    assign issue    = r_k < r_n;
    assign scan_end = !issue && !r_dv;

    bat_ticket_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd_addr (r_k[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = in_range ? S_MAX_SCAN : S_MIN_SCAN;
                end
            end
            S_MAX_SCAN: begin
                if (scan_end) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_MIN_SCAN;
            end
            S_MIN_SCAN: begin
                if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_n        = r_n;
        n_req      = r_req;
        n_who      = r_who;
        n_k        = r_k;
        n_dv       = 1'b0;
        n_dk       = r_k[IDX_W-1:0];
        n_max      = r_max;
        n_own      = r_own;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_found    = r_found;
        n_status   = r_status;
        n_given    = r_given;
        wr         = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_n        = clamp_n;
                    n_req      = t_req'(i_req_type);
                    n_who      = IDX_W'(i_requester);
                    n_k        = '0;
                    n_max      = '0;
                    n_own      = '0;
                    n_best     = '0;
                    n_best_idx = '0;
                    n_found    = 1'b0;
                    n_given    = '0;
                    n_status   = in_range ? ST_OK : ST_RANGE;
                end
            end
            S_MAX_SCAN: begin
                if (issue) begin
                    n_k  = r_k + 1'b1;
                    n_dv = 1'b1;
                end
                if (r_dv) begin
                    if (rd_data > r_max) begin
                        n_max = rd_data;
                    end
                    if (r_dk == r_who) begin
                        n_own = rd_data;
                    end
                end
            end
            S_DECIDE: begin
                // the write lands before the holder walk issues its first read
                n_k = '0;
                if (r_req == REQ_ENTER) begin
                    if (r_own != '0) begin
                        n_status = ST_STATE;
                    end else if (r_max == TICKET_MAX) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        wr.en   = 1'b1;
                        wr.addr = r_who;
                        wr.data = r_max + 1'b1;
                        n_given = r_max + 1'b1;
                    end
                end else begin
                    if (r_own == '0) begin
                        n_status = ST_STATE;
                    end else begin
                        wr.en   = 1'b1;
                        wr.addr = r_who;
                        wr.data = '0;
                    end
                end
            end
            S_MIN_SCAN: begin
                if (issue) begin
                    n_k  = r_k + 1'b1;
                    n_dv = 1'b1;
                end
                if (r_dv && rd_data != '0 && (!r_found || rd_data < r_best)) begin
                    n_best     = rd_data;
                    n_best_idx = r_dk;
                    n_found    = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= ACTIVE_RESET;
            r_dv     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= n_dv;
            if (i_cfg_valid && o_cfg_ready) begin
                r_active <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_req      <= n_req;
        r_who      <= n_who;
        r_k        <= n_k;
        r_dk       <= n_dk;
        r_max      <= n_max;
        r_own      <= n_own;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_found    <= n_found;
        r_status   <= n_status;
        r_given    <= n_given;
    end

    always_comb begin
        busy           = r_state != S_IDLE;
        o_cfg_ready    = r_state == S_IDLE;
        o_strobe       = r_state == S_DONE;
        o_status       = r_status;
        o_ticket_given = GIVEN_W'(r_given);
        o_holder_valid = r_found;
        o_holder_index = HOLDER_W'(r_best_idx);
    end

endmodule

`default_nettype wire

FILE: design/bat_checker.sv
`default_nettype none

module bat_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            start,
    input wire                            busy,
    input wire                            o_strobe,
    input wire [1:0]                      o_status,
    input wire [bat_pkg::GIVEN_W-1:0]     o_ticket_given,
    input wire                            o_holder_valid,
    input wire [bat_pkg::HOLDER_W-1:0]    o_holder_index
);
    import bat_pkg::*;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after start");

    a_strobe_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !busy && !o_strobe)
        else $error("block still busy after result beat");

    a_no_holder_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_holder_valid |-> o_holder_index == '0)
        else $error("holder index set without holder");

    a_err_no_ticket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status != ST_OK |-> o_ticket_given == '0)
        else $error("ticket given on failed request");

    a_enter_holder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_ticket_given != '0 |-> o_holder_valid && o_status == ST_OK)
        else $error("ticket given but no holder reported");

endmodule

bind bakery_ticket_arbiter_unit bat_checker u_bat_checker (.*);

`default_nettype wire

FILE: sim/bat_ledger_pkg.sv
`timescale 1ns / 1ps

package bat_ledger_pkg;
    import bat_pkg::*;

    typedef struct packed {
        t_status             status;
        logic [GIVEN_W-1:0]  given;
        logic                holder_valid;
        logic [HOLDER_W-1:0] holder_index;
    } t_grant;

    class ticket_ledger;
        t_ticket          tickets [MAX_REQUESTERS];
        logic [CFG_W-1:0] active;
        t_grant           grants_due [$];
        int unsigned      faults;
        int unsigned      checked;
        int unsigned      status_seen [4];
        int unsigned      top_given;

        function new();
            foreach (tickets[k]) tickets[k] = '0;
            foreach (status_seen[k]) status_seen[k] = 0;
            active    = ACTIVE_RESET;
            faults    = 0;
            checked   = 0;
            top_given = 0;
        endfunction

        function int unsigned span();
            return (active > MAX_REQUESTERS) ? MAX_REQUESTERS : active;
        endfunction

        function void set_active(logic [CFG_W-1:0] value);
            active = value;
        endfunction

        function t_ticket ticket_of(logic [REQ_W-1:0] who);
            return tickets[who];
        endfunction

        function bit holds(logic [REQ_W-1:0] who);
            return tickets[who] != '0;
        endfunction

        function int unsigned owed();
            return grants_due.size();
        endfunction

        // works out the grant beat for one accepted request
        function void note_request(t_req op, logic [REQ_W-1:0] who);
            t_grant      g;
            t_ticket     top;
            int unsigned n;
            n = span();
            g = '0;
            g.status = ST_OK;
            if (who >= n) begin
                g.status = ST_RANGE;
            end else if (op == REQ_ENTER) begin
                if (tickets[who] != '0) begin
                    g.status = ST_STATE;
                end else begin
                    top = '0;
                    for (int k = 0; k < n; k++)
                        if (tickets[k] > top) top = tickets[k];
                    if (top == TICKET_MAX) begin
                        g.status = ST_OVERFLOW;
                    end else begin
                        tickets[who] = top + 1'b1;
                        g.given      = tickets[who];
                    end
                end
            end else if (tickets[who] == '0) begin
                g.status = ST_STATE;
            end else begin
                tickets[who] = '0;
            end
            // smallest live ticket, lower index wins a tie
            for (int k = 0; k < n; k++) begin
                if (tickets[k] != '0 &&
                    (!g.holder_valid || tickets[k] < tickets[g.holder_index])) begin
                    g.holder_valid = 1'b1;
                    g.holder_index = HOLDER_W'(k);
                end
            end
            grants_due.push_back(g);
        endfunction

        function string show(t_grant g);
            return $sformatf("status=%0d ticket=%0d holder_valid=%0b holder=%0d",
                             g.status, g.given, g.holder_valid, g.holder_index);
        endfunction

        function void flag(string what);
            faults++;
            if (faults <= 10) $display("mismatch at %0t: %s", $realtime, what);
        endfunction

        function void check_grant(t_status st, logic [GIVEN_W-1:0] given,
                                  logic hv, logic [HOLDER_W-1:0] hi);
            t_grant want;
            t_grant got;
            got.status       = st;
            got.given        = given;
            got.holder_valid = hv;
            got.holder_index = hi;
            checked++;
            if (grants_due.size() == 0) begin
                flag({"result beat with nothing outstanding: ", show(got)});
                return;
            end
            want = grants_due.pop_front();
            status_seen[want.status]++;
            if (want.given > top_given) top_given = want.given;
            if (got.status !== want.status || got.given !== want.given ||
                got.holder_valid !== want.holder_valid ||
                got.holder_index !== want.holder_index)
                flag({"expected ", show(want), " got ", show(got)});
        endfunction
    endclass

endpackage

FILE: sim/tb_bakery_ticket_arbiter_unit.sv
`timescale 1ns / 1ps

module tb_bakery_ticket_arbiter_unit;
    import bat_pkg::*;
    import bat_ledger_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 80;
    localparam int SEGMENT_ITEMS = 50;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    logic                i_req_type  = 1'b0;
    logic [REQ_W-1:0]    i_requester = '0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_data  = '0;
    logic                o_strobe;
    t_status             o_status;
    logic [GIVEN_W-1:0]  o_ticket_given;
    logic                o_holder_valid;
    logic [HOLDER_W-1:0] o_holder_index;

    ticket_ledger ledger;
    int unsigned  sender_idle_pct = 6;
    int unsigned  items_sent      = 0;
    int unsigned  cfg_writes      = 0;
    int unsigned  quiet_cycles    = 0;

    bakery_ticket_arbiter_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_requester    (i_requester),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_ticket_given (o_ticket_given),
        .o_holder_valid (o_holder_valid),
        .o_holder_index (o_holder_index)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (o_strobe === 1'b1)
            ledger.check_grant(o_status, o_ticket_given, o_holder_valid, o_holder_index);
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1 ||
            (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input t_req op, input logic [REQ_W-1:0] who);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_req_type  <= op;
        i_requester <= who;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        ledger.note_request(op, who);
        items_sent++;
    endtask

    // wait until every grant has come back and the block is idle
    task automatic settle();
        start <= 1'b0;
        while (ledger.owed() != 0) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_active(input logic [CFG_W-1:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        ledger.set_active(value);
        cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int unsigned      n;
        logic [REQ_W-1:0] who;
        t_req             op;
        n = ledger.span();
        if (n != 0 && $urandom_range(99) < 80) begin
            who = REQ_W'($urandom_range(n - 1));
            op  = ledger.holds(who) ? REQ_RELEASE : REQ_ENTER;
        end else begin
            who = REQ_W'($urandom_range(15));
            op  = $urandom_range(1) ? REQ_RELEASE : REQ_ENTER;
        end
        send_item(op, who);
    endtask

    task automatic random_run(input int unsigned idle_pct, input int unsigned segments);
        int unsigned pause_at;
        sender_idle_pct = idle_pct;
        for (int s = 0; s < segments; s++) begin
            write_active(($urandom_range(99) < 12) ? CFG_W'($urandom_range(31))
                                                   : CFG_W'($urandom_range(16, 1)));
            pause_at = $urandom_range(SEGMENT_ITEMS - 1);
            for (int k = 0; k < SEGMENT_ITEMS; k++) begin
                if (k == pause_at) settle();
                random_item();
            end
        end
    endtask

    initial begin
        ledger = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(REQ_RELEASE, 0);
        send_item(REQ_ENTER, 15);
        send_item(REQ_ENTER, 0);
        send_item(REQ_ENTER, 15);
        send_item(REQ_ENTER, 7);
        send_item(REQ_RELEASE, 15);
        send_item(REQ_RELEASE, 0);
        send_item(REQ_ENTER, 12);
        send_item(REQ_RELEASE, 7);
        send_item(REQ_RELEASE, 12);
        send_item(REQ_ENTER, 12);
        // hidden ticket above the count, then a tie once the count comes back
        write_active(4);
        send_item(REQ_ENTER, 0);
        send_item(REQ_ENTER, 12);
        send_item(REQ_RELEASE, 5);
        write_active(31);
        send_item(REQ_ENTER, 15);
        send_item(REQ_RELEASE, 0);
        send_item(REQ_RELEASE, 12);
        send_item(REQ_RELEASE, 15);
        write_active(0);
        send_item(REQ_ENTER, 0);
        send_item(REQ_RELEASE, 15);
        write_active(1);
        send_item(REQ_ENTER, 0);
        send_item(REQ_ENTER, 1);
        send_item(REQ_RELEASE, 0);
        write_active(16);

        random_run(6, 5);
        random_run(57, 5);
        random_run(0, 5);

        write_active(16);
        for (int k = 0; k < 20; k++) random_item();

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run covered %0d requests over %0d active-count writes, %0d grant beats checked",
                 items_sent, cfg_writes, ledger.checked);
        $display("status ok/range/state/overflow %0d/%0d/%0d/%0d, top ticket %0d, %0d faults",
                 ledger.status_seen[ST_OK], ledger.status_seen[ST_RANGE],
                 ledger.status_seen[ST_STATE], ledger.status_seen[ST_OVERFLOW],
                 ledger.top_given, ledger.faults);
        if (ledger.faults == 0 && ledger.owed() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
